### src/binary_kernel_convolve_threshold_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary kernel convolve threshold block
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_KERNEL_CONVOLVE_THRESHOLD_TOP_ASSERT_SVH
`define BINARY_KERNEL_CONVOLVE_THRESHOLD_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BKCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BKCT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define BKCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define BKCT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### src/bkct_pkg.sv
// ----------------------------------------------------------------------------
// bkct_pkg
// Shared types and constants of the binary kernel convolve threshold block.
// ----------------------------------------------------------------------------
package bkct_pkg;

  // Parameter defaults.
  localparam int MAX_IMAGE_WIDTH_DEF  = 256;
  localparam int MAX_IMAGE_HEIGHT_DEF = 256;
  localparam int MAX_KERNEL_SIZE_DEF  = 15;
  localparam int COEF_FRAC_BITS_DEF   = 12;

  // Field widths.
  localparam int CMD_W      = 2;
  localparam int COORD_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int KIDX_W     = 4;
  localparam int COEF_W     = 16;
  localparam int SUM_W      = 24;
  localparam int IMG_DIM_W  = 9;
  localparam int KER_DIM_W  = 4;
  localparam int THRESH_W   = 46;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 46;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  // Signed source coordinate: 8-bit position plus or minus a kernel radius.
  localparam int SCOORD_W   = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_IMG_WR = 2'd0,
    CMD_KER_WR = 2'd1,
    CMD_EVAL   = 2'd2
  } cmd_e;

  // Controller to datapath.
  typedef struct packed {
    logic item_load;
    logic img_wr;
    logic ker_wr;
    logic tap_init;
    logic tap_issue;
    logic mag_en;
    logic sq_en;
    logic res_load;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_e cmd;
    logic tap_last;
    logic out_free;
  } stat_t;

endpackage

### src/bkct_cfg.sv
// ----------------------------------------------------------------------------
// bkct_cfg
// Configuration registers and the effective sizes derived from them.
// ----------------------------------------------------------------------------
module bkct_cfg #(
  parameter int MAX_IMAGE_WIDTH  = bkct_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT = bkct_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int MAX_KERNEL_SIZE  = bkct_pkg::MAX_KERNEL_SIZE_DEF,
  parameter int COEF_FRAC_BITS   = bkct_pkg::COEF_FRAC_BITS_DEF,
  localparam int KcW = $clog2(MAX_KERNEL_SIZE + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bkct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bkct_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [bkct_pkg::IMG_DIM_W-1:0]      xmax_o,
  output logic [bkct_pkg::IMG_DIM_W-1:0]      ymax_o,
  output logic [KcW-1:0]                      kw_o,
  output logic [KcW-1:0]                      kh_o,
  output logic [bkct_pkg::THRESH_W-1:0]       thresh_o
);
  import bkct_pkg::*;

  localparam logic [THRESH_W-1:0] ThreshRst =
    THRESH_W'((64'd1 << (2 * COEF_FRAC_BITS)) / 64'd5);

  logic [IMG_DIM_W-1:0] img_w_q, img_h_q;
  logic [KER_DIM_W-1:0] ker_w_q, ker_h_q;
  logic [THRESH_W-1:0]  thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= IMG_DIM_W'(256);
      img_h_q  <= IMG_DIM_W'(256);
      ker_w_q  <= KER_DIM_W'(15);
      ker_h_q  <= KER_DIM_W'(15);
      thresh_q <= ThreshRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   img_w_q  <= cfg_data_i[IMG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  img_h_q  <= cfg_data_i[IMG_DIM_W-1:0];
        CFG_KERNEL_WIDTH:  ker_w_q  <= cfg_data_i[KER_DIM_W-1:0];
        CFG_KERNEL_HEIGHT: ker_h_q  <= cfg_data_i[KER_DIM_W-1:0];
        CFG_THRESHOLD:     thresh_q <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero counts as one, a size above the maximum as the maximum.
  always_comb begin
    if (img_w_q == '0) begin
      xmax_o = '0;
    end else if (32'(img_w_q) > MAX_IMAGE_WIDTH) begin
      xmax_o = IMG_DIM_W'(MAX_IMAGE_WIDTH - 1);
    end else begin
      xmax_o = img_w_q - IMG_DIM_W'(1);
    end
    if (img_h_q == '0) begin
      ymax_o = '0;
    end else if (32'(img_h_q) > MAX_IMAGE_HEIGHT) begin
      ymax_o = IMG_DIM_W'(MAX_IMAGE_HEIGHT - 1);
    end else begin
      ymax_o = img_h_q - IMG_DIM_W'(1);
    end
    if (32'(ker_w_q) > MAX_KERNEL_SIZE) begin
      kw_o = KcW'(MAX_KERNEL_SIZE);
    end else begin
      kw_o = KcW'(ker_w_q);
    end
    if (32'(ker_h_q) > MAX_KERNEL_SIZE) begin
      kh_o = KcW'(MAX_KERNEL_SIZE);
    end else begin
      kh_o = KcW'(ker_h_q);
    end
  end

  assign thresh_o = thresh_q;

endmodule

### src/bkct_ctrl.sv
// ----------------------------------------------------------------------------
// bkct_ctrl
// Sequencer for request decode, tap loop, squaring and result hand-off.
// ----------------------------------------------------------------------------
`include "binary_kernel_convolve_threshold_top_assert.svh"

module bkct_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bkct_pkg::stat_t stat_i,
  output bkct_pkg::ctrl_t ctrl_o
);
  import bkct_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MAG   = 3'd4;
  localparam logic [2:0] S_SQ    = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.item_load = 1'b1;
          state_d          = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.cmd)
          CMD_IMG_WR: begin
            ctrl_o.img_wr = 1'b1;
            state_d       = S_RES;
          end
          CMD_KER_WR: begin
            ctrl_o.ker_wr = 1'b1;
            state_d       = S_RES;
          end
          CMD_EVAL: begin
            ctrl_o.tap_init = 1'b1;
            state_d         = S_RUN;
          end
          default: state_d = S_RES;
        endcase
      end
      S_RUN: begin
        ctrl_o.tap_issue = 1'b1;
        if (stat_i.tap_last) begin
          state_d = S_DRAIN;
        end
      end
      // The last tap's read data reaches the accumulator in this cycle.
      S_DRAIN: state_d = S_MAG;
      S_MAG: begin
        ctrl_o.mag_en = 1'b1;
        state_d       = S_SQ;
      end
      S_SQ: begin
        ctrl_o.sq_en = 1'b1;
        state_d      = S_RES;
      end
      S_RES: begin
        if (stat_i.out_free) begin
          ctrl_o.res_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BKCT_ASSERT(a_res_slot_free, clk_i, rst_ni, !ctrl_o.res_load || stat_i.out_free, "result loaded into a full output register")
  `BKCT_ASSERT(a_one_action, clk_i, rst_ni, $onehot0({ctrl_o.img_wr, ctrl_o.ker_wr, ctrl_o.tap_init, ctrl_o.tap_issue}), "conflicting datapath commands")
  `BKCT_ASSERT_NEXT(a_last_tap_drains, clk_i, rst_ni, ctrl_o.tap_issue && stat_i.tap_last, state_q == S_DRAIN, "tap loop did not end on the last tap")
  `BKCT_ASSERT_NEXT(a_init_runs, clk_i, rst_ni, ctrl_o.tap_init, ctrl_o.tap_issue, "tap loop did not start after init")

endmodule

### src/bkct_dp.sv
// ----------------------------------------------------------------------------
// bkct_dp
// Image and kernel stores, tap address generation, accumulator, squarer
// and output register.
// ----------------------------------------------------------------------------
module bkct_dp #(
  parameter int MAX_IMAGE_WIDTH  = bkct_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT = bkct_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int MAX_KERNEL_SIZE  = bkct_pkg::MAX_KERNEL_SIZE_DEF,
  localparam int KcW = $clog2(MAX_KERNEL_SIZE + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bkct_pkg::ctrl_t                    ctrl_i,
  output bkct_pkg::stat_t                    stat_o,
  input  logic [bkct_pkg::CMD_W-1:0]         cmd_i,
  input  logic [bkct_pkg::COORD_W-1:0]       pixel_x_i,
  input  logic [bkct_pkg::COORD_W-1:0]       pixel_y_i,
  input  logic [bkct_pkg::BYTE_W-1:0]        byte_value_i,
  input  logic [bkct_pkg::KIDX_W-1:0]        kernel_col_i,
  input  logic [bkct_pkg::KIDX_W-1:0]        kernel_row_i,
  input  logic signed [bkct_pkg::COEF_W-1:0] coefficient_i,
  input  logic [bkct_pkg::IMG_DIM_W-1:0]     xmax_i,
  input  logic [bkct_pkg::IMG_DIM_W-1:0]     ymax_i,
  input  logic [KcW-1:0]                     kw_i,
  input  logic [KcW-1:0]                     kh_i,
  input  logic [bkct_pkg::THRESH_W-1:0]      thresh_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               result_bit_o,
  output logic signed [bkct_pkg::SUM_W-1:0]  convolution_sum_o
);
  import bkct_pkg::*;

  localparam int RowBytes  = (MAX_IMAGE_WIDTH + 7) / 8;
  localparam int ImgDepth  = RowBytes * MAX_IMAGE_HEIGHT;
  localparam int KerDepth  = MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
  localparam int ImgAw     = (ImgDepth > 1) ? $clog2(ImgDepth) : 1;
  localparam int KerAw     = (KerDepth > 1) ? $clog2(KerDepth) : 1;
  localparam int AccW      = COEF_W + $clog2(KerDepth + 1);
  localparam int SqW       = 2 * AccW;
  localparam int CmpW      = (SqW > THRESH_W) ? SqW : THRESH_W;

  // Request fields held for the whole request.
  cmd_e                     cmd_q;
  logic [COORD_W-1:0]       px_q, py_q;
  logic [BYTE_W-1:0]        bv_q;
  logic [KIDX_W-1:0]        kc_q, kr_q;
  logic signed [COEF_W-1:0] coef_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.item_load) begin
      cmd_q  <= cmd_e'(cmd_i);
      px_q   <= pixel_x_i;
      py_q   <= pixel_y_i;
      bv_q   <= byte_value_i;
      kc_q   <= kernel_col_i;
      kr_q   <= kernel_row_i;
      coef_q <= coefficient_i;
    end
  end

  // Tap counters.
  logic [KcW-1:0] kx_q, ky_q, kx_last, ky_last, rx, ry;

  assign rx      = kw_i >> 1;
  assign ry      = kh_i >> 1;
  assign kx_last = kw_i & ~KcW'(1);
  assign ky_last = kh_i & ~KcW'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_init) begin
      kx_q <= '0;
      ky_q <= '0;
    end else if (ctrl_i.tap_issue) begin
      if (kx_q == kx_last) begin
        kx_q <= '0;
        ky_q <= ky_q + KcW'(1);
      end else begin
        kx_q <= kx_q + KcW'(1);
      end
    end
  end

  // Source coordinates, clamped to the active image.
  logic signed [SCOORD_W-1:0] sx_s, sy_s;
  logic [IMG_DIM_W-1:0]       sx, sy;
  logic                       tap_skip;
  logic [ImgAw-1:0]           img_raddr, img_waddr;
  logic [KerAw-1:0]           ker_raddr, ker_waddr;
  logic                       img_wr_ok, ker_wr_ok;

  always_comb begin
    sx_s = signed'(SCOORD_W'(px_q)) + signed'(SCOORD_W'(kx_q)) - signed'(SCOORD_W'(rx));
    sy_s = signed'(SCOORD_W'(py_q)) + signed'(SCOORD_W'(ky_q)) - signed'(SCOORD_W'(ry));
    if (sx_s < 0) begin
      sx = '0;
    end else if (sx_s > signed'(SCOORD_W'(xmax_i))) begin
      sx = xmax_i;
    end else begin
      sx = sx_s[IMG_DIM_W-1:0];
    end
    if (sy_s < 0) begin
      sy = '0;
    end else if (sy_s > signed'(SCOORD_W'(ymax_i))) begin
      sy = ymax_i;
    end else begin
      sy = sy_s[IMG_DIM_W-1:0];
    end
    // With an even kernel size the last tap index can fall off the store.
    tap_skip  = (32'(kx_q) >= MAX_KERNEL_SIZE) || (32'(ky_q) >= MAX_KERNEL_SIZE);
    img_raddr = ImgAw'(32'(sy) * RowBytes + 32'(sx >> 3));
    ker_raddr = tap_skip ? '0 : KerAw'(32'(ky_q) * MAX_KERNEL_SIZE + 32'(kx_q));
    img_wr_ok = (32'(py_q) < MAX_IMAGE_HEIGHT) && (32'(px_q >> 3) < RowBytes);
    ker_wr_ok = (32'(kc_q) < MAX_KERNEL_SIZE) && (32'(kr_q) < MAX_KERNEL_SIZE);
    img_waddr = img_wr_ok ? ImgAw'(32'(py_q) * RowBytes + 32'(px_q >> 3)) : '0;
    ker_waddr = ker_wr_ok ? KerAw'(32'(kr_q) * MAX_KERNEL_SIZE + 32'(kc_q)) : '0;
  end

  // Stores.
  logic [BYTE_W-1:0]        img_mem [ImgDepth];
  logic signed [COEF_W-1:0] ker_mem [KerDepth];
  logic [BYTE_W-1:0]        img_rd_q;
  logic signed [COEF_W-1:0] ker_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.img_wr && img_wr_ok) begin
      img_mem[img_waddr] <= bv_q;
    end
    if (ctrl_i.tap_issue) begin
      img_rd_q <= img_mem[img_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ker_wr && ker_wr_ok) begin
      ker_mem[ker_waddr] <= coef_q;
    end
    if (ctrl_i.tap_issue) begin
      ker_rd_q <= ker_mem[ker_raddr];
    end
  end

  // Read stage side information.
  logic       rd_vld_q, skip_q;
  logic [2:0] bsel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.tap_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_issue) begin
      skip_q <= tap_skip;
      bsel_q <= ~sx[2:0];
    end
  end

  // Accumulate, magnitude, square.
  logic signed [AccW-1:0] acc_q;
  logic [AccW-1:0]        mag_q;
  logic [SqW-1:0]         sq_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_init) begin
      acc_q <= '0;
    end else if (rd_vld_q && !skip_q && img_rd_q[bsel_q]) begin
      acc_q <= acc_q + AccW'(ker_rd_q);
    end
    if (ctrl_i.mag_en) begin
      mag_q <= acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
    end
    if (ctrl_i.sq_en) begin
      sq_q <= SqW'(mag_q) * SqW'(mag_q);
    end
  end

  // Output register.
  logic                    out_vld_q;
  logic                    out_res_q;
  logic signed [SUM_W-1:0] out_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl_i.res_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      if (cmd_q == CMD_EVAL) begin
        out_res_q <= CmpW'(sq_q) > CmpW'(thresh_i);
        out_sum_q <= SUM_W'(acc_q);
      end else begin
        out_res_q <= 1'b0;
        out_sum_q <= '0;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign result_bit_o      = out_res_q;
  assign convolution_sum_o = out_sum_q;

  assign stat_o.cmd      = cmd_q;
  assign stat_o.tap_last = (kx_q == kx_last) && (ky_q == ky_last);
  assign stat_o.out_free = !out_vld_q || out_ready_i;

endmodule

### src/binary_kernel_convolve_threshold_top.sv
// ----------------------------------------------------------------------------
// binary_kernel_convolve_threshold_top
// Kernel convolution over a stored 1-bit image with a squared-sum threshold.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: cmd; tdata: position, byte, kernel slot, coef
//   m_axis    out        tdata: result_bit, convolution_sum
//   cfg       in         image and kernel size, threshold (write only)
//
// An evaluate request reads (2*rx+1)*(2*ry+1) kernel taps, one tap per cycle,
// through the image and kernel store read ports.
// Requests are accepted one at a time; a finished result waits in the output
// register while the next request is accepted and processed.
// Reset restores the size and threshold registers; store contents are
// undefined until written.
// ----------------------------------------------------------------------------
module binary_kernel_convolve_threshold_top #(
  parameter int MAX_IMAGE_WIDTH  = bkct_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT = bkct_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int MAX_KERNEL_SIZE  = bkct_pkg::MAX_KERNEL_SIZE_DEF,
  parameter int COEF_FRAC_BITS   = bkct_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: pixel_x[7:0], pixel_y[15:8], byte_value[23:16], kernel_col[27:24],
  //        kernel_row[31:28], coefficient[47:32]
  input  logic [bkct_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [bkct_pkg::CMD_W-1:0]         s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: result_bit[0], convolution_sum[24:1], zero pad[31:25]
  output logic [bkct_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we_i,
  input  logic [bkct_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bkct_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bkct_pkg::*;

  localparam int KcW = $clog2(MAX_KERNEL_SIZE + 1);

  ctrl_t                   ctrl;
  stat_t                   stat;
  logic [IMG_DIM_W-1:0]    xmax, ymax;
  logic [KcW-1:0]          kw, kh;
  logic [THRESH_W-1:0]     thresh;
  logic                    res_bit;
  logic signed [SUM_W-1:0] res_sum;

  bkct_cfg #(
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT(MAX_IMAGE_HEIGHT),
    .MAX_KERNEL_SIZE (MAX_KERNEL_SIZE),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .xmax_o    (xmax),
    .ymax_o    (ymax),
    .kw_o      (kw),
    .kh_o      (kh),
    .thresh_o  (thresh)
  );

  bkct_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  bkct_dp #(
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT(MAX_IMAGE_HEIGHT),
    .MAX_KERNEL_SIZE (MAX_KERNEL_SIZE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .cmd_i            (s_axis_tuser),
    .pixel_x_i        (s_axis_tdata[7:0]),
    .pixel_y_i        (s_axis_tdata[15:8]),
    .byte_value_i     (s_axis_tdata[23:16]),
    .kernel_col_i     (s_axis_tdata[27:24]),
    .kernel_row_i     (s_axis_tdata[31:28]),
    .coefficient_i    (signed'(s_axis_tdata[47:32])),
    .xmax_i           (xmax),
    .ymax_i           (ymax),
    .kw_i             (kw),
    .kh_i             (kh),
    .thresh_i         (thresh),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .result_bit_o     (res_bit),
    .convolution_sum_o(res_sum)
  );

  assign m_axis_tdata = {7'b0, res_sum, res_bit};

endmodule
